>>> hdl/qesm_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter package
// Shared widths, constants, register indexes, types and helper functions.
// ----------------------------------------------------------------------------
package qesm_pkg;

  // Fixed field widths.
  localparam int NOW_W   = 32;
  localparam int SPEED_W = 32;
  localparam int NUM_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Defaults for the top level parameters.
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] NUMERATOR_RST = 32'd109226623;
  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 32'd100000;

  // Saturation limits of the signed speed.
  localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMERATOR = 1'b0,
    REG_TIMEOUT   = 1'b1
  } qesm_reg_t;

  // Classification of one sample, made by the front end.
  typedef struct packed {
    logic edge_seen;
    logic backward;
  } qesm_cls_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } qesm_state_t;

  // Backward order is 00 -> 01 -> 11 -> 10 -> 00, levels written as AB.
  function automatic logic is_backward(input logic [1:0] from_ab, input logic [1:0] to_ab);
    logic res;
    res = 1'b0;
    case (from_ab)
      2'b00:   res = (to_ab == 2'b01);
      2'b01:   res = (to_ab == 2'b11);
      2'b11:   res = (to_ab == 2'b10);
      2'b10:   res = (to_ab == 2'b00);
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  // Turns an unsigned quotient into the saturated signed speed.
  function automatic logic [SPEED_W-1:0] sat_speed(input logic [NUM_W-1:0] mag,
                                                   input logic back);
    logic [SPEED_W-1:0] res;
    if (back) begin
      res = mag[NUM_W-1] ? SPEED_MIN : SPEED_W'(~mag + 1'b1);
    end else begin
      res = mag[NUM_W-1] ? SPEED_MAX : SPEED_W'(mag);
    end
    return res;
  endfunction

endpackage

>>> hdl/qesm_if.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter channels
// Valid/ready interfaces for the sample channel and the result channel.
// ----------------------------------------------------------------------------
interface qesm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       a_level;
  logic                       b_level;
  logic [qesm_pkg::NOW_W-1:0] now_us;

  modport source (output valid, a_level, b_level, now_us, input ready);
  modport sink   (input valid, a_level, b_level, now_us, output ready);
endinterface

interface qesm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qesm_pkg::SPEED_W-1:0] speed_q16;
  logic                                edge_seen;
  logic                                timed_out;
  logic                                backward;

  modport source (output valid, speed_q16, edge_seen, timed_out, backward, input ready);
  modport sink   (input valid, speed_q16, edge_seen, timed_out, backward, output ready);
endinterface

>>> hdl/qesm_front.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter front end
// Accepts samples, detects level changes and their direction, fills the queue.
// ----------------------------------------------------------------------------
module qesm_front #(
  parameter int TIME_WIDTH = qesm_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  qesm_in_if.sink               in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output qesm_pkg::qesm_cls_t   q_cls,
  output logic [TIME_WIDTH-1:0] q_now
);
  import qesm_pkg::*;

  logic prev_a_r, prev_a_nxt;
  logic prev_b_r, prev_b_nxt;

  // The previous levels always follow the last accepted sample.
  always_comb begin
    in_ch.ready     = !q_full;
    q_push          = in_ch.valid && !q_full;
    q_cls.edge_seen = (in_ch.a_level != prev_a_r) || (in_ch.b_level != prev_b_r);
    q_cls.backward  = is_backward({prev_a_r, prev_b_r}, {in_ch.a_level, in_ch.b_level});
    q_now           = TIME_WIDTH'({32'd0, in_ch.now_us});
    prev_a_nxt      = q_push ? in_ch.a_level : prev_a_r;
    prev_b_nxt      = q_push ? in_ch.b_level : prev_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      prev_b_r <= 1'b0;
    end else begin
      prev_a_r <= prev_a_nxt;
      prev_b_r <= prev_b_nxt;
    end
  end

endmodule

>>> hdl/qesm_fifo.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter queue
// Small first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module qesm_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = qesm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);
  import qesm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    not_empty  = (count_r != '0);
    do_push    = push && !full;
    do_pop     = pop && not_empty;
    rd_data    = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/qesm_div.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter divider
// Radix-2 restoring divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module qesm_div #(
  parameter int NUM_W = qesm_pkg::NUM_W,
  parameter int DEN_W = qesm_pkg::TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  import qesm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  // The quotient register starts out holding the dividend; its top bit is
  // shifted into the partial remainder on each step.
  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(NUM_W - 1);
      quo_nxt = numer;
      rem_nxt = '0;
      den_nxt = denom;
    end else if (run_r) begin
      if (!diff[DEN_W]) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
    done = done_r;
    quot = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

>>> hdl/qesm_back.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter back end
// Holds the speed state, runs the divider, handles timeouts, drives results.
// ----------------------------------------------------------------------------
module qesm_back #(
  parameter int TIME_WIDTH = qesm_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qesm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qesm_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          q_valid,
  input  qesm_pkg::qesm_cls_t           q_cls,
  input  logic [TIME_WIDTH-1:0]         q_now,
  output logic                          q_pop,
  qesm_out_if.source                    out_ch
);
  import qesm_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  qesm_state_t          state_r, state_nxt;
  logic [CFG_W-1:0]     num_r, num_nxt;
  logic [CFG_W-1:0]     tmo_r, tmo_nxt;
  logic [TIME_WIDTH-1:0] last_event_r, last_event_nxt;
  logic [SPEED_W-1:0]   speed_r, speed_nxt;
  logic                 last_back_r, last_back_nxt;
  logic                 item_edge_r, item_edge_nxt;
  logic                 item_tmo_r, item_tmo_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]   out_speed_r, out_speed_nxt;
  logic                 out_edge_r, out_edge_nxt;
  logic                 out_tmo_r, out_tmo_nxt;
  logic                 out_back_r, out_back_nxt;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;

  qesm_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (num_r),
    .denom (elapsed),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    elapsed        = q_now - last_event_r;
    state_nxt      = state_r;
    num_nxt        = num_r;
    tmo_nxt        = tmo_r;
    last_event_nxt = last_event_r;
    speed_nxt      = speed_r;
    last_back_nxt  = last_back_r;
    item_edge_nxt  = item_edge_r;
    item_tmo_nxt   = item_tmo_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_speed_nxt  = out_speed_r;
    out_edge_nxt   = out_edge_r;
    out_tmo_nxt    = out_tmo_r;
    out_back_nxt   = out_back_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_NUMERATOR: num_nxt = cfg_wdata;
        REG_TIMEOUT:   tmo_nxt = cfg_wdata;
        default:       num_nxt = num_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          item_edge_nxt = q_cls.edge_seen;
          item_tmo_nxt  = 1'b0;
          state_nxt     = ST_WRITE;
          if (q_cls.edge_seen) begin
            last_back_nxt  = q_cls.backward;
            last_event_nxt = q_now;
            if (elapsed == '0) begin
              speed_nxt = q_cls.backward ? SPEED_MIN : SPEED_MAX;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end else if ((speed_r != '0) && (CMP_W'(elapsed) > CMP_W'(tmo_r))) begin
            speed_nxt      = '0;
            last_event_nxt = q_now;
            item_tmo_nxt   = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          speed_nxt = sat_speed(div_quot, last_back_r);
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = speed_r;
          out_edge_nxt  = item_edge_r;
          out_tmo_nxt   = item_tmo_r;
          out_back_nxt  = last_back_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_ch.valid     = out_valid_r;
    out_ch.speed_q16 = out_speed_r;
    out_ch.edge_seen = out_edge_r;
    out_ch.timed_out = out_tmo_r;
    out_ch.backward  = out_back_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_r        <= NUMERATOR_RST;
      tmo_r        <= TIMEOUT_RST;
      last_event_r <= '0;
      speed_r      <= '0;
      last_back_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_r        <= num_nxt;
      tmo_r        <= tmo_nxt;
      last_event_r <= last_event_nxt;
      speed_r      <= speed_nxt;
      last_back_r  <= last_back_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_edge_r <= item_edge_nxt;
    item_tmo_r  <= item_tmo_nxt;
    out_speed_r <= out_speed_nxt;
    out_edge_r  <= out_edge_nxt;
    out_tmo_r   <= out_tmo_nxt;
    out_back_r  <= out_back_nxt;
  end

endmodule

>>> hdl/quadrature_edge_speed_meter.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter
// Measures encoder speed as a constant divided by the time between edges.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                                   Handshake
//   in_ch     sink       a_level, b_level, now_us                   valid/ready
//   out_ch    source     speed_q16, edge_seen, timed_out, backward  valid/ready
//   cfg_*     sink       cfg_we, cfg_index, cfg_wdata               write enable
//
// A sample that shows an edge with a nonzero elapsed time goes through the
// 32-step radix-2 divider in the back end, which it shares with no other
// unit. Any other sample passes from the idle state to the write state.
// The sample queue accepts new requests while the back end works, so the
// input stalls only once the queue is full. A result that is not taken holds
// the back end in its write state. Reset is synchronous and active low; it
// loads the register defaults and clears the speed state and the queue.
// ----------------------------------------------------------------------------
module quadrature_edge_speed_meter #(
  parameter int TIME_WIDTH  = qesm_pkg::TIME_WIDTH_DEF,
  parameter int QUEUE_DEPTH = qesm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  qesm_in_if.sink                        in_ch,
  qesm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [qesm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qesm_pkg::CFG_W-1:0]     cfg_wdata
);
  import qesm_pkg::*;

  // A queue entry is the classification of the sample and its timestamp.
  localparam int ENTRY_W = $bits(qesm_cls_t) + TIME_WIDTH;

  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_valid;
  qesm_cls_t             front_cls;
  logic [TIME_WIDTH-1:0] front_now;
  logic [ENTRY_W-1:0]    q_rd_data;
  qesm_cls_t             back_cls;
  logic [TIME_WIDTH-1:0] back_now;

  // The front end only needs the previous levels, which always follow the
  // last accepted sample, so it can classify a request ahead of the back end.
  qesm_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_cls  (front_cls),
    .q_now  (front_now)
  );

  qesm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   ({front_cls, front_now}),
    .pop       (pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  assign back_cls = q_rd_data[ENTRY_W-1:TIME_WIDTH];
  assign back_now = q_rd_data[TIME_WIDTH-1:0];

  // The back end owns the event time, the speed and the direction flag, and
  // the configuration registers that act on them.
  qesm_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cls     (back_cls),
    .q_now     (back_now),
    .q_pop     (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> hdl/qesm_checker.sv
// ----------------------------------------------------------------------------
// Quadrature edge speed meter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module qesm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [qesm_pkg::SPEED_W-1:0] out_speed_q16,
  input logic                                out_edge_seen,
  input logic                                out_timed_out,
  input logic                                out_backward
);
  import qesm_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_q16)
      && $stable(out_edge_seen) && $stable(out_timed_out) && $stable(out_backward))
    else $error("result changed while stalled");

  // A result never shows both an edge and a timeout.
  a_edge_or_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_edge_seen && out_timed_out))
    else $error("edge and timeout in one result");

  // A timeout always leaves the speed at zero.
  a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_speed_q16 == '0)
    else $error("timeout with nonzero speed");

  // A negative speed only follows a backward edge.
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_speed_q16[SPEED_W-1] |-> out_backward)
    else $error("negative speed without backward edge");

endmodule

bind quadrature_edge_speed_meter qesm_checker u_qesm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_speed_q16 (out_ch.speed_q16),
  .out_edge_seen (out_ch.edge_seen),
  .out_timed_out (out_ch.timed_out),
  .out_backward  (out_ch.backward)
);
